[rtl/nlmm_pkg.sv]
// Shared constants and types for the number list membership matcher.
package nlmm_pkg;

  localparam int unsigned NUMBER_BITS_DEF = 16;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned VALUE_W         = 10;
  localparam int unsigned S_TDATA_W       = 24;
  localparam int unsigned M_TDATA_W       = 8;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_GR_LO = 8'h21;
  localparam logic [CHAR_W-1:0] CHAR_GR_HI = 8'h7E;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;

  typedef struct packed {
    logic format_error;
    logic in_list;
  } result_t;

endpackage

[rtl/nlmm_parser.sv]
// Per-character list parser: phase, accumulator and decision state.
module nlmm_parser #(
  parameter int unsigned NUMBER_BITS = nlmm_pkg::NUMBER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [nlmm_pkg::CHAR_W-1:0]   text_char_i,
  input  logic [nlmm_pkg::VALUE_W-1:0]  test_value_i,
  output nlmm_pkg::result_t             result_o
);
  import nlmm_pkg::*;

  localparam int unsigned CMP_W = (NUMBER_BITS > VALUE_W) ? NUMBER_BITS : VALUE_W;
  localparam int unsigned MAC_W = NUMBER_BITS + 4;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_TOP    = 3'd1,
    PH_PRE    = 3'd2,
    PH_NUM    = 3'd3,
    PH_POST   = 3'd4,
    PH_HI_PRE = 3'd5,
    PH_HI_NUM = 3'd6
  } phase_e;

  typedef struct packed {
    phase_e                 phase;
    logic [NUMBER_BITS-1:0] acc;
    logic                   dec;
    logic                   ver;
    logic                   err;
  } pstate_t;

  pstate_t state_q, state_d, cur;

  logic c_zero, c_digit, c_graph, c_alpha, c_comma, c_dash, c_star;
  logic [NUMBER_BITS-1:0] dig;
  logic [MAC_W-1:0]       mac;
  logic [NUMBER_BITS-1:0] acc_mac;
  logic [CMP_W-1:0]       val_x, acc_x;
  logic eq_acc, ge_acc, le_acc, eq_zero;

  assign c_zero  = (text_char_i == CHAR_NUL);
  assign c_digit = (text_char_i >= CHAR_ZERO) && (text_char_i <= CHAR_NINE);
  assign c_graph = (text_char_i >= CHAR_GR_LO) && (text_char_i <= CHAR_GR_HI);
  assign c_alpha = ((text_char_i >= CHAR_UC_A) && (text_char_i <= CHAR_UC_Z)) ||
                   ((text_char_i >= CHAR_LC_A) && (text_char_i <= CHAR_LC_Z));
  assign c_comma = (text_char_i == CHAR_COMMA);
  assign c_dash  = (text_char_i == CHAR_DASH);
  assign c_star  = (text_char_i == CHAR_STAR);

  assign dig = NUMBER_BITS'(text_char_i[3:0]);
  assign mac = (MAC_W'(state_q.acc) << 3) + (MAC_W'(state_q.acc) << 1) + MAC_W'(dig);
  assign acc_mac = (mac[MAC_W-1 -: 4] != 4'd0) ? {NUMBER_BITS{1'b1}}
                                               : mac[NUMBER_BITS-1:0];

  assign val_x   = CMP_W'(test_value_i);
  assign acc_x   = CMP_W'(state_q.acc);
  assign eq_acc  = (val_x == acc_x);
  assign ge_acc  = (val_x >= acc_x);
  assign le_acc  = (val_x <= acc_x);
  assign eq_zero = (test_value_i == '0);

  function automatic pstate_t post_step(pstate_t s, logic eq, logic ge);
    pstate_t r;
    r = s;
    r.phase = PH_POST;
    if (c_zero || (c_graph && c_alpha)) begin
      r.dec = 1'b1;
      r.ver = eq;
    end else if (!c_graph) begin
      r.phase = PH_POST;
    end else if (c_comma) begin
      if (eq) begin
        r.dec = 1'b1;
        r.ver = 1'b1;
      end else begin
        r.phase = PH_TOP;
      end
    end else if (c_dash) begin
      if (ge) begin
        r.acc   = '0;
        r.phase = PH_HI_PRE;
      end else begin
        r.phase = PH_TOP;
      end
    end else begin
      r.err = 1'b1;
      r.dec = 1'b1;
      r.ver = 1'b0;
    end
    return r;
  endfunction

  function automatic pstate_t pre_step(pstate_t s);
    pstate_t r;
    r = s;
    r.phase = PH_PRE;
    if (c_zero) begin
      r.dec = 1'b1;
      r.ver = eq_zero;
    end else if (!c_graph) begin
      r.phase = PH_PRE;
    end else if (c_star) begin
      r.dec = 1'b1;
      r.ver = 1'b0;
    end else if (c_digit) begin
      r.acc   = dig;
      r.phase = PH_NUM;
    end else begin
      r.acc = '0;
      r = post_step(r, eq_zero, 1'b1);
    end
    return r;
  endfunction

  always_comb begin
    cur = state_q;
    if (!state_q.dec) begin
      case (state_q.phase)
        PH_TOP: begin
          if (c_zero) begin
            cur.dec = 1'b1;
            cur.ver = 1'b0;
          end else begin
            cur = pre_step(state_q);
          end
        end
        PH_PRE: cur = pre_step(state_q);
        PH_NUM: begin
          if (c_digit) begin
            cur.acc = acc_mac;
          end else begin
            cur = post_step(state_q, eq_acc, ge_acc);
          end
        end
        PH_POST: cur = post_step(state_q, eq_acc, ge_acc);
        PH_HI_PRE: begin
          if (c_zero) begin
            cur.dec = 1'b1;
            cur.ver = eq_zero;
          end else if (!c_graph) begin
            cur.phase = PH_HI_PRE;
          end else if (c_digit) begin
            cur.acc   = dig;
            cur.phase = PH_HI_NUM;
          end else if (eq_zero) begin
            cur.dec = 1'b1;
            cur.ver = 1'b1;
          end else begin
            cur = pre_step(state_q);
          end
        end
        PH_HI_NUM: begin
          if (c_digit) begin
            cur.acc = acc_mac;
          end else if (le_acc) begin
            cur.dec = 1'b1;
            cur.ver = 1'b1;
          end else if (c_zero) begin
            cur.dec = 1'b1;
            cur.ver = 1'b0;
          end else begin
            cur = pre_step(state_q);
          end
        end
        default: begin
          cur.phase = PH_LEAD;
          if (c_zero) begin
            cur.dec = 1'b1;
            cur.ver = 1'b0;
          end else if (c_digit) begin
            cur.acc   = dig;
            cur.phase = PH_NUM;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    if (step_i) begin
      if (c_zero) begin
        state_d = '{phase: PH_LEAD, acc: '0, dec: 1'b0, ver: 1'b0, err: 1'b0};
      end else begin
        state_d = cur;
      end
    end
  end

  assign result_o.in_list      = cur.ver;
  assign result_o.format_error = cur.err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_LEAD, acc: '0, dec: 1'b0, ver: 1'b0, err: 1'b0};
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/number_list_membership_matcher_core.sv]
// Top level of the number list membership matcher with stream ports.
// The verdict appears on the master side in the cycle after the zero terminator transfer.
// Throughput: one character per cycle unless a held verdict stalls the slave side; the per-character
// parse step and the saturating multiply by ten sit between the parser state and the result register.
// A character other than the terminator produces no output transfer.
// Reset clears the parser to the leading-skip phase and clears the output valid flag; the result register is not reset.
module number_list_membership_matcher_core #(
  parameter int unsigned NUMBER_BITS = nlmm_pkg::NUMBER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] text_char, [17:8] test_value, [23:18] zero
  input  logic [nlmm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] in_list, [1] format_error, [7:2] zero
  output logic [nlmm_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import nlmm_pkg::*;

  logic                 s_xfer;
  logic [CHAR_W-1:0]    text_char;
  logic [VALUE_W-1:0]   test_value;
  result_t              result;
  result_t              out_q;
  logic                 out_valid_q, out_valid_d;

  assign text_char     = s_axis_tdata[CHAR_W-1:0];
  assign test_value    = s_axis_tdata[CHAR_W +: VALUE_W];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  nlmm_parser #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s_xfer),
    .text_char_i (text_char),
    .test_value_i(test_value),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (s_xfer && (text_char == CHAR_NUL)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && (text_char == CHAR_NUL)) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-2){1'b0}}, out_q.format_error, out_q.in_list};

endmodule
